>>> src/msde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msde_pkg
// Shared opcodes, function codes, ALU operation codes and the decoded
// control bundle for the MIPS subset decode/execute pipeline.
// ----------------------------------------------------------------------------
package msde_pkg;

  // primary opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTIU = 6'h0b;
  localparam logic [5:0] OP_ANDI  = 6'h0c;
  localparam logic [5:0] OP_ORI   = 6'h0d;
  localparam logic [5:0] OP_LUI   = 6'h0f;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2b;

  // r-type function codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  // address region kept by j/jal
  localparam logic [31:0] REGION_MASK = 32'hf000_0000;

  typedef enum logic [3:0] {
    ALU_NONE,
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_OR,
    ALU_NOR,
    ALU_SLTU,
    ALU_SLL,
    ALU_SRL,
    ALU_PASSB
  } alu_op_e;

  // decoded control bundle, all zero apart from illegal for a bad word
  typedef struct packed {
    alu_op_e    alu_op;
    logic [4:0] shamt;
    logic [4:0] dest_reg;
    logic       reg_write;
    logic       mem_read;
    logic       mem_write;
    logic       mem_to_reg;
    logic       is_branch;
    logic       is_bne;
    logic       is_jump;
    logic       is_jr;
    logic       illegal;
  } ctrl_t;

endpackage

>>> src/msde_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msde_decode
// Main control decoder: turns an instruction word into the control bundle
// and selects the second ALU operand (rt or an extended immediate).
// ----------------------------------------------------------------------------
module msde_decode
  import msde_pkg::*;
(
  input  logic [31:0] instr_word_i,
  input  logic [31:0] rt_value_i,
  output ctrl_t       ctrl_o,
  output logic [31:0] op_b_o
);

  logic [5:0]  opcode;
  logic [5:0]  funct;
  logic [15:0] imm;
  logic [31:0] simm;
  logic [31:0] zimm;

  assign opcode = instr_word_i[31:26];
  assign funct  = instr_word_i[5:0];
  assign imm    = instr_word_i[15:0];
  assign simm   = {{16{imm[15]}}, imm};
  assign zimm   = {16'h0000, imm};

  // opcode and function decode
  always_comb begin
    ctrl_o          = '0;
    ctrl_o.alu_op   = ALU_NONE;
    ctrl_o.dest_reg = instr_word_i[20:16];
    op_b_o          = rt_value_i;
    unique case (opcode) inside
      OP_ADDIU: begin
        ctrl_o.alu_op    = ALU_ADD;
        ctrl_o.reg_write = 1'b1;
        op_b_o           = simm;
      end
      OP_SLTIU: begin
        ctrl_o.alu_op    = ALU_SLTU;
        ctrl_o.reg_write = 1'b1;
        op_b_o           = simm;
      end
      OP_ANDI: begin
        ctrl_o.alu_op    = ALU_AND;
        ctrl_o.reg_write = 1'b1;
        op_b_o           = zimm;
      end
      OP_ORI: begin
        ctrl_o.alu_op    = ALU_OR;
        ctrl_o.reg_write = 1'b1;
        op_b_o           = zimm;
      end
      OP_LUI: begin
        ctrl_o.alu_op    = ALU_PASSB;
        ctrl_o.reg_write = 1'b1;
        op_b_o           = {imm, 16'h0000};
      end
      OP_LW: begin
        ctrl_o.alu_op     = ALU_ADD;
        ctrl_o.reg_write  = 1'b1;
        ctrl_o.mem_read   = 1'b1;
        ctrl_o.mem_to_reg = 1'b1;
        op_b_o            = simm;
      end
      OP_SW: begin
        ctrl_o.alu_op    = ALU_ADD;
        ctrl_o.mem_write = 1'b1;
        op_b_o           = simm;
      end
      OP_BEQ: begin
        ctrl_o.is_branch = 1'b1;
      end
      OP_BNE: begin
        ctrl_o.is_branch = 1'b1;
        ctrl_o.is_bne    = 1'b1;
      end
      OP_J, OP_JAL: begin
        ctrl_o.is_jump = 1'b1;
      end
      OP_RTYPE: begin
        ctrl_o.reg_write = 1'b1;
        ctrl_o.dest_reg  = instr_word_i[15:11];
        ctrl_o.shamt     = instr_word_i[10:6];
        unique case (funct) inside
          FN_ADDU: ctrl_o.alu_op = ALU_ADD;
          FN_SUBU: ctrl_o.alu_op = ALU_SUB;
          FN_AND:  ctrl_o.alu_op = ALU_AND;
          FN_OR:   ctrl_o.alu_op = ALU_OR;
          FN_NOR:  ctrl_o.alu_op = ALU_NOR;
          FN_SLTU: ctrl_o.alu_op = ALU_SLTU;
          FN_SLL:  ctrl_o.alu_op = ALU_SLL;
          FN_SRL:  ctrl_o.alu_op = ALU_SRL;
          FN_JR: begin
            ctrl_o.reg_write = 1'b0;
            ctrl_o.dest_reg  = instr_word_i[20:16];
            ctrl_o.shamt     = '0;
            ctrl_o.is_jump   = 1'b1;
            ctrl_o.is_jr     = 1'b1;
          end
          default: begin
            ctrl_o         = '0;
            ctrl_o.alu_op  = ALU_NONE;
            ctrl_o.illegal = 1'b1;
          end
        endcase
      end
      default: begin
        ctrl_o         = '0;
        ctrl_o.alu_op  = ALU_NONE;
        ctrl_o.illegal = 1'b1;
      end
    endcase
  end

endmodule

>>> src/msde_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msde_alu
// Integer ALU: wrapping add/subtract, logic ops, unsigned set-less-than
// and logical shifts of operand b by the shift amount.
// ----------------------------------------------------------------------------
module msde_alu
  import msde_pkg::*;
(
  input  alu_op_e     alu_op_i,
  input  logic [31:0] op_a_i,
  input  logic [31:0] op_b_i,
  input  logic [4:0]  shamt_i,
  output logic [31:0] result_o
);

  // operation select
  always_comb begin
    case (alu_op_i)
      ALU_ADD:   result_o = op_a_i + op_b_i;
      ALU_SUB:   result_o = op_a_i - op_b_i;
      ALU_AND:   result_o = op_a_i & op_b_i;
      ALU_OR:    result_o = op_a_i | op_b_i;
      ALU_NOR:   result_o = ~(op_a_i | op_b_i);
      ALU_SLTU:  result_o = {31'd0, (op_a_i < op_b_i)};
      ALU_SLL:   result_o = op_b_i << shamt_i;
      ALU_SRL:   result_o = op_b_i >> shamt_i;
      ALU_PASSB: result_o = op_b_i;
      default:   result_o = '0;
    endcase
  end

endmodule

>>> src/mips_subset_decode_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_decode_execute
// Three-stage decode/execute pipeline for a MIPS-32 integer subset.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one instruction word with
//   the forwarded rs and rt values and the address of the instruction plus
//   four. Output channel (out_valid_o / out_ready_i) carries one result per
//   instruction: control flags, destination register, ALU result or load/store
//   address, branch target and taken flag, jump target and an illegal flag.
//   An illegal word gives all zero fields except illegal.
//   Each accepted instruction passes the decode register, the execute
//   register and the output register before its result is offered.
//   Throughput: one instruction per cycle while out_ready_i lets results
//   go; the deepest logic is the 32-bit ALU in the execute stage.
//   Stalls: when out_ready_i is low the pipeline fills its empty stages and
//   then holds; in_ready_o drops only once every stage holds an item. Nothing
//   is lost or repeated.
//   Reset: rst_ni clears all stage valid bits; the block is empty afterwards.
// ----------------------------------------------------------------------------
module mips_subset_decode_execute
  import msde_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instr_word_i,
  input  logic [31:0] rs_value_i,
  input  logic [31:0] rt_value_i,
  input  logic [31:0] next_pc_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] alu_result_o,
  output logic [4:0]  dest_reg_o,
  output logic [31:0] branch_target_o,
  output logic        branch_taken_o,
  output logic [31:0] jump_target_o,
  output logic        is_jump_o,
  output logic        is_branch_o,
  output logic        reg_write_o,
  output logic        mem_read_o,
  output logic        mem_write_o,
  output logic        mem_to_reg_o,
  output logic        illegal_o
);

  // stage enables
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_ready, s2_ready, s3_ready;

  assign s3_ready   = !s3_valid_q || out_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // ---------------------------------------------------------------- stage 1
  ctrl_t       dec_ctrl;
  logic [31:0] dec_op_b;

  msde_decode u_decode (
    .instr_word_i (instr_word_i),
    .rt_value_i   (rt_value_i),
    .ctrl_o       (dec_ctrl),
    .op_b_o       (dec_op_b)
  );

  ctrl_t       s1_ctrl_q;
  logic [31:0] s1_rs_q, s1_rt_q, s1_op_b_q, s1_npc_q, s1_simm_q;
  logic [25:0] s1_target_q;

  // decode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_ctrl_q   <= dec_ctrl;
      s1_rs_q     <= rs_value_i;
      s1_rt_q     <= rt_value_i;
      s1_op_b_q   <= dec_op_b;
      s1_npc_q    <= next_pc_i;
      s1_simm_q   <= {{16{instr_word_i[15]}}, instr_word_i[15:0]};
      s1_target_q <= instr_word_i[25:0];
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic [31:0] alu_res;
  logic [31:0] jump_tgt_d;
  logic        taken_d;

  msde_alu u_alu (
    .alu_op_i (s1_ctrl_q.alu_op),
    .op_a_i   (s1_rs_q),
    .op_b_i   (s1_op_b_q),
    .shamt_i  (s1_ctrl_q.shamt),
    .result_o (alu_res)
  );

  // branch compare and jump target
  always_comb begin
    taken_d = s1_ctrl_q.is_branch &&
              ((s1_rs_q == s1_rt_q) ^ s1_ctrl_q.is_bne);
    if (!s1_ctrl_q.is_jump) begin
      jump_tgt_d = '0;
    end else if (s1_ctrl_q.is_jr) begin
      jump_tgt_d = s1_rs_q;
    end else begin
      jump_tgt_d = (s1_npc_q & REGION_MASK) | {4'h0, s1_target_q, 2'b00};
    end
  end

  ctrl_t       s2_ctrl_q;
  logic [31:0] s2_alu_q, s2_jump_q, s2_npc_q, s2_simm_q;
  logic        s2_taken_q;

  // execute register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_ctrl_q  <= s1_ctrl_q;
      s2_alu_q   <= alu_res;
      s2_jump_q  <= jump_tgt_d;
      s2_taken_q <= taken_d;
      s2_npc_q   <= s1_npc_q;
      s2_simm_q  <= s1_simm_q;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic [31:0] branch_tgt_d;

  // branch target add, zeroed for an illegal word
  always_comb begin
    if (s2_ctrl_q.illegal) begin
      branch_tgt_d = '0;
    end else begin
      branch_tgt_d = s2_npc_q + {s2_simm_q[29:0], 2'b00};
    end
  end

  ctrl_t       s3_ctrl_q;
  logic [31:0] s3_alu_q, s3_jump_q, s3_branch_q;
  logic        s3_taken_q;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      s3_ctrl_q   <= s2_ctrl_q;
      s3_alu_q    <= s2_alu_q;
      s3_jump_q   <= s2_jump_q;
      s3_taken_q  <= s2_taken_q;
      s3_branch_q <= branch_tgt_d;
    end
  end

  // result ports
  assign out_valid_o     = s3_valid_q;
  assign alu_result_o    = s3_alu_q;
  assign dest_reg_o      = s3_ctrl_q.dest_reg;
  assign branch_target_o = s3_branch_q;
  assign branch_taken_o  = s3_taken_q;
  assign jump_target_o   = s3_jump_q;
  assign is_jump_o       = s3_ctrl_q.is_jump;
  assign is_branch_o     = s3_ctrl_q.is_branch;
  assign reg_write_o     = s3_ctrl_q.reg_write;
  assign mem_read_o      = s3_ctrl_q.mem_read;
  assign mem_write_o     = s3_ctrl_q.mem_write;
  assign mem_to_reg_o    = s3_ctrl_q.mem_to_reg;
  assign illegal_o       = s3_ctrl_q.illegal;

endmodule

>>> tb/sv/mips_subset_decode_execute_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_decode_execute_tb
// Self-checking bench for the MIPS subset decode/execute unit. A directed
// table covers every instruction, the operand and immediate extremes and
// illegal words. A random part with mostly well-formed instructions follows.
// Each accepted instruction is predicted in the bench. Each result transfer
// is compared field by field with the oldest prediction. Both handshakes
// idle at random, with stretches of full rate.
// ----------------------------------------------------------------------------
module mips_subset_decode_execute_tb;
  import msde_pkg::*;

  // codes the block must reject
  localparam logic [5:0] OP_BAD = 6'h3f;
  localparam logic [5:0] FN_BAD = 6'h01;

  localparam logic [5:0] IMM_OPS [11] = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDIU, OP_SLTIU,
                                          OP_ANDI, OP_ORI, OP_LUI, OP_LW, OP_SW};
  localparam logic [5:0] R_FNS [9] = '{FN_SLL, FN_SRL, FN_JR, FN_ADDU, FN_SUBU, FN_AND,
                                       FN_OR, FN_NOR, FN_SLTU};

  typedef struct packed {
    logic [31:0] alu_result;
    logic [4:0]  dest_reg;
    logic [31:0] branch_target;
    logic        branch_taken;
    logic [31:0] jump_target;
    logic        is_jump;
    logic        is_branch;
    logic        reg_write;
    logic        mem_read;
    logic        mem_write;
    logic        mem_to_reg;
    logic        illegal;
  } exec_res_t;

  typedef struct packed {
    logic [31:0] iw;
    logic [31:0] rs_val;
    logic [31:0] rt_val;
    logic [31:0] npc;
    logic        has_literal;
    exec_res_t   literal;
  } dir_row_t;

  localparam exec_res_t ILLEGAL_RES = '{illegal: 1'b1, default: '0};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] instr_word_i;
  logic [31:0] rs_value_i;
  logic [31:0] rt_value_i;
  logic [31:0] next_pc_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] alu_result_o;
  logic [4:0]  dest_reg_o;
  logic [31:0] branch_target_o;
  logic        branch_taken_o;
  logic [31:0] jump_target_o;
  logic        is_jump_o;
  logic        is_branch_o;
  logic        reg_write_o;
  logic        mem_read_o;
  logic        mem_write_o;
  logic        mem_to_reg_o;
  logic        illegal_o;

  // literal expectation travelling with the instruction on the input channel
  logic        row_has_literal;
  exec_res_t   row_literal;

  bit          idle_on;
  int          err_cnt;
  int          n_accepted;
  int          n_checked;
  int          n_illegal;
  int          n_branch;
  int          n_taken;
  int          n_jump;
  int          n_mem;
  exec_res_t   pending_exec_q [$];
  dir_row_t    dir_tab [$];

  always #6 clk_i = ~clk_i;

  mips_subset_decode_execute i_dut (.*);

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic exec_res_t exec_instr(logic [31:0] iw, logic [31:0] rs,
                                           logic [31:0] rt, logic [31:0] npc);
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  sh;
    logic [15:0] imm;
    logic [31:0] simm;
    logic [31:0] zimm;
    logic        bad;
    exec_res_t   r;
    op   = iw[31:26];
    fn   = iw[5:0];
    sh   = iw[10:6];
    imm  = iw[15:0];
    simm = {{16{imm[15]}}, imm};
    zimm = {16'h0000, imm};
    bad  = 1'b0;
    r    = '0;
    r.dest_reg = iw[20:16];
    case (op)
      OP_ADDIU: begin r.alu_result = rs + simm; r.reg_write = 1'b1; end
      OP_ANDI:  begin r.alu_result = rs & zimm; r.reg_write = 1'b1; end
      OP_LUI:   begin r.alu_result = {imm, 16'h0000}; r.reg_write = 1'b1; end
      OP_ORI:   begin r.alu_result = rs | zimm; r.reg_write = 1'b1; end
      OP_SLTIU: begin r.alu_result = {31'b0, rs < simm}; r.reg_write = 1'b1; end
      OP_LW: begin
        r.alu_result = rs + simm;
        r.reg_write  = 1'b1;
        r.mem_read   = 1'b1;
        r.mem_to_reg = 1'b1;
      end
      OP_SW: begin r.alu_result = rs + simm; r.mem_write = 1'b1; end
      OP_BEQ: begin r.is_branch = 1'b1; r.branch_taken = (rs == rt); end
      OP_BNE: begin r.is_branch = 1'b1; r.branch_taken = (rs != rt); end
      OP_J, OP_JAL: begin
        r.is_jump     = 1'b1;
        r.jump_target = (npc & REGION_MASK) | {4'b0000, iw[25:0], 2'b00};
      end
      OP_RTYPE: begin
        r.reg_write = 1'b1;
        r.dest_reg  = iw[15:11];
        case (fn)
          FN_ADDU: r.alu_result = rs + rt;
          FN_SUBU: r.alu_result = rs - rt;
          FN_AND:  r.alu_result = rs & rt;
          FN_OR:   r.alu_result = rs | rt;
          FN_NOR:  r.alu_result = ~(rs | rt);
          FN_SLTU: r.alu_result = {31'b0, rs < rt};
          FN_SLL:  r.alu_result = rt << sh;
          FN_SRL:  r.alu_result = rt >> sh;
          FN_JR: begin
            r.reg_write   = 1'b0;
            r.dest_reg    = iw[20:16];
            r.is_jump     = 1'b1;
            r.jump_target = rs;
          end
          default: bad = 1'b1;
        endcase
      end
      default: bad = 1'b1;
    endcase
    r.branch_target = npc + {simm[29:0], 2'b00};
    // an illegal word clears everything but its flag
    if (bad) r = ILLEGAL_RES;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // encoders and operand picks
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd, logic [4:0] sh);
    return {OP_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  // operands lean on the corners of unsigned and signed compare and carry
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0:       v = 32'h0000_0000;
      1:       v = 32'hffff_ffff;
      2:       v = 32'h8000_0000;
      3:       v = 32'h7fff_ffff;
      4:       v = $urandom_range(0, 15);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("[%0t] ERROR %s", $time, what);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] got,
                           input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %h expected %h",
                                n_checked, name, got, want));
  endtask

  // input transfers queue a prediction, output transfers check the oldest one
  always @(posedge clk_i) begin
    exec_res_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        want = row_has_literal ? row_literal
                               : exec_instr(instr_word_i, rs_value_i, rt_value_i, next_pc_i);
        pending_exec_q.push_back(want);
        n_accepted++;
        n_illegal += int'(want.illegal);
        n_branch  += int'(want.is_branch);
        n_taken   += int'(want.branch_taken);
        n_jump    += int'(want.is_jump);
        n_mem     += int'(want.mem_read | want.mem_write);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_exec_q.size() == 0) begin
          report_mismatch("result transfer with no instruction outstanding");
        end else begin
          want = pending_exec_q.pop_front();
          cmp_field("alu_result", alu_result_o, want.alu_result);
          cmp_field("dest_reg", 32'(dest_reg_o), 32'(want.dest_reg));
          cmp_field("branch_target", branch_target_o, want.branch_target);
          cmp_field("branch_taken", 32'(branch_taken_o), 32'(want.branch_taken));
          cmp_field("jump_target", jump_target_o, want.jump_target);
          cmp_field("is_jump", 32'(is_jump_o), 32'(want.is_jump));
          cmp_field("is_branch", 32'(is_branch_o), 32'(want.is_branch));
          cmp_field("reg_write", 32'(reg_write_o), 32'(want.reg_write));
          cmp_field("mem_read", 32'(mem_read_o), 32'(want.mem_read));
          cmp_field("mem_write", 32'(mem_write_o), 32'(want.mem_write));
          cmp_field("mem_to_reg", 32'(mem_to_reg_o), 32'(want.mem_to_reg));
          cmp_field("illegal", 32'(illegal_o), 32'(want.illegal));
          n_checked++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random stall before each transfer
  // ---------------------------------------------------------------------------

  initial begin
    int n;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      n = idle_on ? $urandom_range(0, 9) : 0;
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // ---------------------------------------------------------------------------
  // instruction side
  // ---------------------------------------------------------------------------

  task automatic send_instr(input logic [31:0] iw, input logic [31:0] rs,
                            input logic [31:0] rt, input logic [31:0] npc,
                            input logic has_lit, input exec_res_t lit);
    int n;
    n = idle_on ? $urandom_range(0, 9) : 0;
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    instr_word_i    <= iw;
    rs_value_i      <= rs;
    rt_value_i      <= rt;
    next_pc_i       <= npc;
    row_has_literal <= has_lit;
    row_literal     <= lit;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  // mostly legal instructions with random fields, some noise words
  task automatic send_random_batch(input int count);
    logic [31:0] iw;
    logic [31:0] rs_v;
    logic [31:0] rt_v;
    logic [31:0] rnd;
    int          sel;
    for (int k = 0; k < count; k++) begin
      sel  = $urandom_range(0, 99);
      rnd  = $urandom();
      rs_v = pick_operand();
      // equal operands often enough to take both branch outcomes
      rt_v = ($urandom_range(0, 2) == 0) ? rs_v : pick_operand();
      if (sel < 40)
        iw = {OP_RTYPE, rnd[25:6], R_FNS[4'($urandom_range(0, 8))]};
      else if (sel < 85)
        iw = {IMM_OPS[4'($urandom_range(0, 10))], rnd[25:0]};
      else if (sel < 93)
        iw = {OP_RTYPE, rnd[25:0]};
      else
        iw = rnd;
      // immediate corners
      case ($urandom_range(0, 7))
        0:       iw[15:0] = 16'h0000;
        1:       iw[15:0] = 16'hffff;
        2:       iw[15:0] = 16'h8000;
        3:       iw[15:0] = 16'h7fff;
        default: ;
      endcase
      send_instr(iw, rs_v, rt_v, pick_operand(), 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    instr_word_i    = '0;
    rs_value_i      = '0;
    rt_value_i      = '0;
    next_pc_i       = '0;
    out_ready_i     = 1'b0;
    row_has_literal = 1'b0;
    row_literal     = '0;
    idle_on         = 1'b1;

    // directed rows: literal expectation where it is plain, predictor otherwise
    dir_tab.push_back(dir_row_t'{{OP_BAD, 26'h3ff_ffff}, '1, '1, '1, 1'b1, ILLEGAL_RES});
    dir_tab.push_back(dir_row_t'{enc_r(FN_BAD, 5'd31, 5'd31, 5'd31, 5'd31),
                                 32'h1, 32'h1, 32'h4, 1'b1, ILLEGAL_RES});
    dir_tab.push_back(dir_row_t'{{OP_J, 26'h3ff_ffff}, 32'h0, 32'h0, 32'hf000_0004, 1'b1,
                                 exec_res_t'{dest_reg: 5'd31, branch_target: 32'hf000_0000,
                                             jump_target: 32'hffff_fffc, is_jump: 1'b1,
                                             default: '0}});
    dir_tab.push_back(dir_row_t'{enc_i(OP_LUI, 5'd0, 5'd0, 16'hffff), 32'h1234_5678,
                                 32'h0, 32'h0, 1'b1,
                                 exec_res_t'{alu_result: 32'hffff_0000,
                                             branch_target: 32'hffff_fffc, reg_write: 1'b1,
                                             default: '0}});
    dir_tab.push_back(dir_row_t'{enc_i(OP_ADDIU, 5'd1, 5'd2, 16'h0001), 32'hffff_ffff,
                                 32'h0, 32'h100, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{enc_i(OP_ADDIU, 5'd1, 5'd31, 16'h8000), 32'h0,
                                 32'h0, 32'hffff_ffff, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{enc_i(OP_SLTIU, 5'd3, 5'd4, 16'hffff), 32'hffff_fff0,
                                 32'h0, 32'h0, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{enc_i(OP_SLTIU, 5'd3, 5'd4, 16'h0000), 32'hffff_ffff,
                                 32'h0, 32'h0, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{enc_i(OP_ANDI, 5'd5, 5'd6, 16'h8000), 32'hffff_ffff,
                                 32'h0, 32'h40, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{enc_i(OP_ORI, 5'd5, 5'd6, 16'hffff), 32'h0,
                                 32'h0, 32'h40, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{enc_i(OP_LW, 5'd7, 5'd8, 16'hfffc), 32'h0000_1000,
                                 32'h0, 32'h2000, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{enc_i(OP_SW, 5'd7, 5'd8, 16'h7fff), 32'h0,
                                 32'hffff_ffff, 32'h2000, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{enc_i(OP_BEQ, 5'd9, 5'd10, 16'h8000), 32'h8000_0000,
                                 32'h8000_0000, 32'h0, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{enc_i(OP_BEQ, 5'd9, 5'd10, 16'h0004), 32'h8000_0000,
                                 32'h0000_0001, 32'h10, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{enc_i(OP_BNE, 5'd9, 5'd10, 16'hfffe), 32'hffff_ffff,
                                 32'hffff_ffff, 32'h10, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{enc_i(OP_BNE, 5'd9, 5'd10, 16'h7fff), 32'h0,
                                 32'hffff_ffff, 32'hffff_fffc, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{{OP_JAL, 26'h000_0000}, 32'h5, 32'h6, 32'hffff_ffff,
                                 1'b0, '0});
    dir_tab.push_back(dir_row_t'{enc_r(FN_JR, 5'd31, 5'd0, 5'd0, 5'd0), 32'h8000_0001,
                                 32'h0, 32'h400, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{enc_r(FN_ADDU, 5'd1, 5'd2, 5'd31, 5'd0), 32'hffff_ffff,
                                 32'h1, 32'h0, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{enc_r(FN_SUBU, 5'd1, 5'd2, 5'd3, 5'd0), 32'h0,
                                 32'h1, 32'h0, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{enc_r(FN_AND, 5'd1, 5'd2, 5'd3, 5'd7), 32'hf0f0_f0f0,
                                 32'hff00_ff00, 32'h8, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{enc_r(FN_OR, 5'd1, 5'd2, 5'd3, 5'd0), 32'h0f0f_0f0f,
                                 32'hf000_0000, 32'h8, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{enc_r(FN_NOR, 5'd0, 5'd0, 5'd0, 5'd0), 32'h0,
                                 32'h0, 32'h0, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{enc_r(FN_SLTU, 5'd4, 5'd5, 5'd6, 5'd0), 32'h8000_0000,
                                 32'h1, 32'h0, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{enc_r(FN_SLL, 5'd31, 5'd5, 5'd6, 5'd31), 32'hffff_ffff,
                                 32'h1, 32'h0, 1'b0, '0});
    dir_tab.push_back(dir_row_t'{enc_r(FN_SRL, 5'd31, 5'd5, 5'd6, 5'd31), 32'h0,
                                 32'hffff_ffff, 32'h0, 1'b0, '0});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_tab[i])
      send_instr(dir_tab[i].iw, dir_tab[i].rs_val, dir_tab[i].rt_val, dir_tab[i].npc,
                 dir_tab[i].has_literal, dir_tab[i].literal);

    // random phases, the second one at full rate on both sides
    send_random_batch(100);
    idle_on = 1'b0;
    send_random_batch(100);
    idle_on = 1'b1;
    send_random_batch(100);

    // hold off until the pipeline has drained completely
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_exec_q.size() != 0);

    send_random_batch(200);
    in_valid_i <= 1'b0;

    // drain, then keep clocking to catch stray results
    do @(posedge clk_i); while (pending_exec_q.size() != 0);
    repeat (8) @(posedge clk_i);

    $display("summary: %0d instructions (%0d directed), %0d results checked, %0d illegal",
             n_accepted, dir_tab.size(), n_checked, n_illegal);
    $display("summary: %0d branches (%0d taken), %0d jumps, %0d loads/stores",
             n_branch, n_taken, n_jump, n_mem);
    if (err_cnt == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout: %0d results still outstanding", pending_exec_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
